[rtl/grle_pkg.sv]
// Shared types and constants for the glyph run-length pixel decoder.
package grle_pkg;

   localparam logic [3:0] PIX_WHITE = 4'h0;
   localparam logic [3:0] PIX_BLACK = 4'hf;

   // Pattern selected by the top three bits of a code byte.
   localparam logic [2:0] PAT_WHITE_RUN   = 3'd0;
   localparam logic [2:0] PAT_BLACK_RUN   = 3'd1;
   localparam logic [2:0] PAT_WHITE_B1    = 3'd2;
   localparam logic [2:0] PAT_WHITE_B2    = 3'd3;
   localparam logic [2:0] PAT_WHITE_GREYA = 3'd4;
   localparam logic [2:0] PAT_WHITE_GREYB = 3'd5;
   localparam logic [2:0] PAT_GREY_PAIRA  = 3'd6;
   localparam logic [2:0] PAT_GREY_PAIRB  = 3'd7;

   localparam int PROD_BITS = 16;
   localparam int LIM_BITS  = PROD_BITS + 1;
   localparam int IDX_OUT_BITS = 16;

   // Two pixel segments: first a run of up to 31, then up to two of another value.
   typedef struct packed {
      logic [3:0] first_value;
      logic [4:0] first_count;
      logic [3:0] second_value;
      logic [1:0] second_count;
   } plan_type;

endpackage

[rtl/grle_req_if.sv]
// Request channel: one run-length code byte with glyph start information.
interface grle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;
   logic       start_glyph;
   logic [7:0] glyph_width;

   modport source (output valid, output code_byte, output start_glyph,
                   output glyph_width, input ready);
   modport sink (input valid, input code_byte, input start_glyph,
                 input glyph_width, output ready);
endinterface

[rtl/grle_rsp_if.sv]
// Response channel: one decoded pixel.
interface grle_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  pixel_value;
   logic [15:0] pixel_index;
   logic        last_of_run;
   logic        glyph_full;

   modport source (output valid, output pixel_value, output pixel_index,
                   output last_of_run, output glyph_full, input ready);
   modport sink (input valid, input pixel_value, input pixel_index,
                 input last_of_run, input glyph_full, output ready);
endinterface

[rtl/grle_code_decode.sv]
// Code byte decoder: turns a code byte into a two-segment pixel plan.
module grle_code_decode (
   input  logic [7:0]         code_byte,
   output grle_pkg::plan_type plan
);
   import grle_pkg::*;

   logic [4:0] run5;
   logic [2:0] hi3;
   logic [2:0] lo3;

   assign run5 = code_byte[4:0];
   assign hi3  = code_byte[5:3];
   assign lo3  = code_byte[2:0];

   always_comb begin
      unique case (code_byte[7:5])
         PAT_WHITE_RUN: begin
            plan = '{PIX_WHITE, run5, PIX_WHITE, 2'd0};
         end
         PAT_BLACK_RUN: begin
            plan = '{PIX_BLACK, run5, PIX_WHITE, 2'd0};
         end
         PAT_WHITE_B1: begin
            plan = '{PIX_WHITE, run5, PIX_BLACK, 2'd1};
         end
         PAT_WHITE_B2: begin
            plan = '{PIX_WHITE, run5, PIX_BLACK, 2'd2};
         end
         PAT_WHITE_GREYA, PAT_WHITE_GREYB: begin
            plan = '{PIX_WHITE, {2'b00, hi3}, {lo3, 1'b0}, 2'd1};
         end
         PAT_GREY_PAIRA, PAT_GREY_PAIRB: begin
            plan = '{{hi3, 1'b0}, 5'd1, {lo3, 1'b0}, 2'd1};
         end
      endcase
   end
endmodule

[rtl/glyph_rle_pixel_decoder_unit.sv]
// Top level of the glyph run-length pixel decoder.
//
//   channel  | role   | moves
//   ---------+--------+----------------------------------------------
//   req_ch   | sink   | one code byte item, optional glyph start/width
//   rsp_ch   | source | one pixel item per cycle while a byte expands, unless rsp_ch stalls
//   csr_*    | write  | char_height, sampled when a glyph starts
//
// A code byte is accepted in idle, passes a limit state first when it
// starts a glyph, then steps each pixel through the shared position
// compare/increment unit, plus a step at each segment end.
// Reset is synchronous: no glyph, limit 0, char_height 16.
// A stalled rsp_ch holds the pixel sequencer; req_ch is ready only when idle.
module glyph_rle_pixel_decoder_unit #(
   parameter int INDEX_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   grle_req_if.sink   req_ch,
   grle_rsp_if.source rsp_ch,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata
);
   import grle_pkg::*;

   localparam int LW  = INDEX_BITS + 1;
   localparam int CW  = (LW > LIM_BITS) ? LW : LIM_BITS;
   localparam int MW  = (LW > IDX_OUT_BITS) ? LW : IDX_OUT_BITS;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_LIMIT = 2'd1;
   localparam logic [1:0] ST_RUN   = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [7:0]           height_ff;
   logic [PROD_BITS-1:0] prod_ff;
   logic [LW-1:0]        limit_ff, limit_in;
   logic [LW-1:0]        pos_ff, pos_in;
   logic                 full_ff, full_in;
   logic                 seg_ff, seg_in;
   logic [4:0]           cnt_ff, cnt_in;
   logic [3:0]           v1_ff, v2_ff;
   logic [1:0]           c2_ff;
   plan_type             plan;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [3:0]           pix_ff;
   logic [15:0]          idx_ff;
   logic                 last_ff, gfull_ff;

   logic                 accept;
   logic                 step;
   logic                 drop;
   logic                 emit;
   logic [LW-1:0]        pos_next;
   logic                 fill;
   logic [LIM_BITS-1:0]  even_prod;
   logic [CW-1:0]        prod_ext, cap_ext;
   logic [MW-1:0]        pos_wide;

   grle_code_decode u_decode (
      .code_byte (req_ch.code_byte),
      .plan      (plan)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign step         = (state_ff == ST_RUN) && (!rsp_valid_ff || rsp_ch.ready);

   // Shared position unit: limit check and increment.
   assign drop     = full_ff || (pos_ff >= limit_ff);
   assign pos_next = pos_ff + LW'(1);
   assign fill     = (pos_next == limit_ff);
   assign emit     = step && (cnt_ff != 5'd0) && !drop;

   // Round the product up to even, then clamp to the index range.
   assign even_prod = {1'b0, prod_ff} + LIM_BITS'(prod_ff[0]);
   assign prod_ext  = CW'(even_prod);
   assign cap_ext   = CW'(1) << INDEX_BITS;
   assign limit_in  = (prod_ext > cap_ext) ? LW'(cap_ext) : LW'(prod_ext);

   assign pos_wide  = MW'(pos_ff);

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      full_in  = full_ff;
      seg_in   = seg_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               seg_in   = 1'b0;
               cnt_in   = plan.first_count;
               state_in = req_ch.start_glyph ? ST_LIMIT : ST_RUN;
            end
         end
         ST_LIMIT: begin
            pos_in   = '0;
            full_in  = (limit_in == '0);
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (step) begin
               if (cnt_ff == 5'd0) begin
                  if (!seg_ff && c2_ff != 2'd0) begin
                     seg_in = 1'b1;
                     cnt_in = {3'b000, c2_ff};
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else if (drop) begin
                  // Glyph is full: drop the rest of this byte.
                  full_in  = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  pos_in  = pos_next;
                  full_in = fill;
                  cnt_in  = cnt_ff - 5'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         height_ff    <= 8'd16;
         limit_ff     <= '0;
         pos_ff       <= '0;
         full_ff      <= 1'b0;
         seg_ff       <= 1'b0;
         cnt_ff       <= 5'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         full_ff      <= full_in;
         seg_ff       <= seg_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            height_ff <= csr_wdata;
         end
         if (state_ff == ST_LIMIT) begin
            limit_ff <= limit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prod_ff <= PROD_BITS'(req_ch.glyph_width) * PROD_BITS'(height_ff);
         v1_ff   <= plan.first_value;
         v2_ff   <= plan.second_value;
         c2_ff   <= plan.second_count;
      end
      if (emit) begin
         pix_ff   <= seg_ff ? v2_ff : v1_ff;
         idx_ff   <= pos_wide[15:0];
         gfull_ff <= fill;
         last_ff  <= fill || ((cnt_ff == 5'd1) && (seg_ff || c2_ff == 2'd0));
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.pixel_value = pix_ff;
   assign rsp_ch.pixel_index = idx_ff;
   assign rsp_ch.last_of_run = last_ff;
   assign rsp_ch.glyph_full  = gfull_ff;

   a_pos_in_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (pos_ff <= limit_ff))
      else $error("pixel position past glyph limit");

   a_full_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && gfull_ff) |-> last_ff)
      else $error("glyph full pixel not marked last of run");

   a_no_emit_full: assert property (@(posedge clock) disable iff (reset)
      emit |-> !full_ff)
      else $error("pixel emitted after glyph full");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff)
      else $error("emitted pixel not presented");

   a_idle_after_full: assert property (@(posedge clock) disable iff (reset)
      (step && cnt_ff != 5'd0 && drop) |=> (state_ff == ST_IDLE))
      else $error("sequencer continued past full glyph");
endmodule

[test/glyph_rle_pixel_decoder_unit_tb.sv]
// Self-checking testbench for the glyph run-length pixel decoder: table, then random glyphs.
`timescale 1ns / 100ps

module glyph_rle_pixel_decoder_unit_tb;
   import grle_pkg::*;

   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int PHASE_ITEMS   = 88;
   localparam int DIR_ROWS      = 26;

   typedef struct packed {
      logic [3:0]  value;
      logic [15:0] index;
      logic        last;
      logic        full;
   } pixel_type;

   // One directed row: either a height write or a code byte item.
   // Typed rows carry their pixels as a uniform run starting at idx0.
   typedef struct packed {
      bit         cfg;
      logic [7:0] hgt;
      logic [7:0] code;
      bit         start;
      logic [7:0] width;
      bit         typed;
      int         n;
      logic [3:0] val;
      int         idx0;
      bit         full_end;
   } row_type;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [7:0] csr_wdata;

   grle_req_if req_if ();
   grle_rsp_if rsp_if ();

   glyph_rle_pixel_decoder_unit #(
      .INDEX_BITS(16)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_if),
      .rsp_ch   (rsp_if),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata)
   );

   // Decoder state mirrored by the testbench
   logic [7:0]  height_q = 8'd16;
   int unsigned pos_q    = 0;
   int unsigned limit_q  = 0;
   bit          full_q   = 1'b0;

   pixel_type byte_px [$];
   pixel_type pixels_due [$];

   int  mismatches = 0;
   int  cycles     = 0;
   bit  idle_on    = 1'b0;
   int  stall_left = 0;

   row_type dir_rows [0:DIR_ROWS-1] = '{
      // no glyph started yet: nothing comes out
      '{0, 8'd0,   8'h3F, 0, 8'd5,   1, 0,  PIX_WHITE, 0,  0},
      '{0, 8'd0,   8'hFF, 0, 8'd255, 1, 0,  PIX_WHITE, 0,  0},
      // width 1 at reset height 16: black run of 31 cut to 16
      '{0, 8'd0,   8'h3F, 1, 8'd1,   1, 16, PIX_BLACK, 0,  1},
      '{0, 8'd0,   8'h1F, 0, 8'd0,   1, 0,  PIX_WHITE, 0,  0},
      // zero width: everything dropped
      '{0, 8'd0,   8'hFF, 1, 8'd0,   1, 0,  PIX_WHITE, 0,  0},
      '{1, 8'd255, 8'h00, 0, 8'd0,   0, 0,  PIX_WHITE, 0,  0},
      // empty white and black runs
      '{0, 8'd0,   8'h00, 1, 8'd255, 1, 0,  PIX_WHITE, 0,  0},
      '{0, 8'd0,   8'h20, 0, 8'd0,   1, 0,  PIX_WHITE, 0,  0},
      '{0, 8'd0,   8'h1F, 0, 8'd0,   1, 31, PIX_WHITE, 0,  0},
      '{0, 8'd0,   8'h3F, 0, 8'd0,   1, 31, PIX_BLACK, 31, 0},
      '{0, 8'd0,   8'h40, 0, 8'd0,   0, 0,  PIX_WHITE, 0,  0},
      '{0, 8'd0,   8'h5F, 0, 8'd0,   0, 0,  PIX_WHITE, 0,  0},
      '{0, 8'd0,   8'h60, 0, 8'd0,   0, 0,  PIX_WHITE, 0,  0},
      '{0, 8'd0,   8'h7F, 0, 8'd0,   0, 0,  PIX_WHITE, 0,  0},
      '{0, 8'd0,   8'h80, 0, 8'd0,   0, 0,  PIX_WHITE, 0,  0},
      '{0, 8'd0,   8'hBF, 0, 8'd0,   0, 0,  PIX_WHITE, 0,  0},
      '{0, 8'd0,   8'hA5, 0, 8'd0,   0, 0,  PIX_WHITE, 0,  0},
      '{0, 8'd0,   8'hC0, 0, 8'd0,   0, 0,  PIX_WHITE, 0,  0},
      '{0, 8'd0,   8'hFF, 0, 8'd0,   0, 0,  PIX_WHITE, 0,  0},
      '{0, 8'd0,   8'hD6, 0, 8'd0,   0, 0,  PIX_WHITE, 0,  0},
      '{1, 8'd1,   8'h00, 0, 8'd0,   0, 0,  PIX_WHITE, 0,  0},
      // limit 3 rounds up to 4; the run overflows and its blacks are dropped
      '{0, 8'd0,   8'h7F, 1, 8'd3,   1, 4,  PIX_WHITE, 0,  1},
      '{0, 8'd0,   8'h3F, 0, 8'd0,   1, 0,  PIX_WHITE, 0,  0},
      '{1, 8'd3,   8'h00, 0, 8'd0,   0, 0,  PIX_WHITE, 0,  0},
      '{0, 8'd0,   8'hE9, 1, 8'd1,   0, 0,  PIX_WHITE, 0,  0},
      '{0, 8'd0,   8'h42, 0, 8'd0,   0, 0,  PIX_WHITE, 0,  0}
   };

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("glyph_rle_pixel_decoder_unit_tb NOT OK");
         $finish;
      end
   end

   // Receiver back-pressure in bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= $urandom_range(0, 7);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_pixel
      pixel_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pixels_due.size() == 0) begin
            $error("pixel with nothing due: index %0d value %0d",
                   rsp_if.pixel_index, rsp_if.pixel_value);
            mismatches++;
         end else begin
            want = pixels_due.pop_front();
            if (rsp_if.pixel_value !== want.value) begin
               $error("pixel_value expected %0d got %0d", want.value, rsp_if.pixel_value);
               mismatches++;
            end
            if (rsp_if.pixel_index !== want.index) begin
               $error("pixel_index expected %0d got %0d", want.index, rsp_if.pixel_index);
               mismatches++;
            end
            if (rsp_if.last_of_run !== want.last) begin
               $error("last_of_run expected %0d got %0d", want.last, rsp_if.last_of_run);
               mismatches++;
            end
            if (rsp_if.glyph_full !== want.full) begin
               $error("glyph_full expected %0d got %0d", want.full, rsp_if.glyph_full);
               mismatches++;
            end
         end
      end
   end

   function automatic void put_pixel(input logic [3:0] v);
      pixel_type px;
      if (full_q || pos_q >= limit_q) begin
         full_q = 1'b1;
         return;
      end
      px.value = v;
      px.index = pos_q[15:0];
      px.last  = 1'b0;
      pos_q++;
      px.full  = (pos_q >= limit_q);
      if (px.full)
         full_q = 1'b1;
      byte_px.push_back(px);
   endfunction

   function automatic void put_run(input logic [3:0] v, input int unsigned count);
      for (int unsigned i = 0; i < count; i++)
         put_pixel(v);
   endfunction

   // Expand one code byte into byte_px, updating the mirrored glyph state
   function automatic void expand_code(input logic [7:0] code, input bit start,
                                       input logic [7:0] width);
      int unsigned p;
      int unsigned run5;
      logic [2:0]  hi3;
      logic [2:0]  lo3;
      run5 = 32'(code[4:0]);
      hi3  = code[5:3];
      lo3  = code[2:0];
      byte_px.delete();
      if (start) begin
         p = 32'(width) * 32'(height_q);
         p += p & 1;
         if (p > 65536)
            p = 65536;
         limit_q = p;
         pos_q   = 0;
         full_q  = (p == 0);
      end
      case (code[7:5])
         PAT_WHITE_RUN: put_run(PIX_WHITE, run5);
         PAT_BLACK_RUN: put_run(PIX_BLACK, run5);
         PAT_WHITE_B1: begin
            put_run(PIX_WHITE, run5);
            put_pixel(PIX_BLACK);
         end
         PAT_WHITE_B2: begin
            put_run(PIX_WHITE, run5);
            put_run(PIX_BLACK, 2);
         end
         PAT_WHITE_GREYA, PAT_WHITE_GREYB: begin
            put_run(PIX_WHITE, 32'(hi3));
            put_pixel({lo3, 1'b0});
         end
         default: begin
            put_pixel({hi3, 1'b0});
            put_pixel({lo3, 1'b0});
         end
      endcase
      if (byte_px.size() > 0)
         byte_px[byte_px.size() - 1].last = 1'b1;
   endfunction

   task automatic send_code(input logic [7:0] code, input bit start, input logic [7:0] width,
                            input bit predicted);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      expand_code(code, start, width);
      if (predicted)
         foreach (byte_px[i]) pixels_due.push_back(byte_px[i]);
      req_if.valid       <= 1'b1;
      req_if.code_byte   <= code;
      req_if.start_glyph <= start;
      req_if.glyph_width <= width;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Hold off until every pixel is out and the decoder has gone quiet
   task automatic settle();
      req_if.valid <= 1'b0;
      while (pixels_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_height(input logic [7:0] h);
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= h;
      @(posedge clock);
      csr_we    <= 1'b0;
      height_q  = h;
   endtask

   initial begin
      row_type    r;
      pixel_type  px;
      logic [7:0] phase_hts [0:4];
      int         sent;
      int         glen;
      int         roll;

      clock                = 1'b0;
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_wdata            = 8'd0;
      req_if.valid         = 1'b0;
      req_if.code_byte     = 8'd0;
      req_if.start_glyph   = 1'b0;
      req_if.glyph_width   = 8'd0;
      rsp_if.ready         = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      idle_on = 1'b1;
      for (int i = 0; i < DIR_ROWS; i++) begin
         r = dir_rows[i];
         if (r.cfg) begin
            write_height(r.hgt);
         end else begin
            if (r.typed)
               for (int k = 0; k < r.n; k++) begin
                  px.value = r.val;
                  px.index = 16'(r.idx0 + k);
                  px.last  = (k == r.n - 1);
                  px.full  = r.full_end && (k == r.n - 1);
                  pixels_due.push_back(px);
               end
            send_code(r.code, r.start, r.width, !r.typed);
         end
      end

      phase_hts[0] = 8'd16;
      phase_hts[1] = 8'd1;
      phase_hts[2] = 8'd255;
      phase_hts[3] = 8'($urandom_range(2, 254));
      phase_hts[4] = 8'd2;
      for (int ph = 0; ph < 5; ph++) begin
         write_height(phase_hts[ph]);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            // last phase runs without any idling
            idle_on = (ph != 4) && ($urandom_range(0, 3) != 0);
            roll = $urandom_range(0, 9);
            if (roll == 0) begin
               send_code(8'($urandom), 1'($urandom), 8'($urandom), 1'b1);
               sent++;
            end else begin
               send_code(8'($urandom), 1'b1,
                         (roll == 1) ? 8'($urandom) : 8'($urandom_range(1, 6)), 1'b1);
               glen = $urandom_range(1, 10);
               for (int k = 0; k < glen; k++)
                  send_code(8'($urandom), 1'b0, 8'($urandom), 1'b1);
               sent += glen + 1;
            end
         end
      end

      idle_on = 1'b0;
      settle();
      if (mismatches == 0)
         $display("glyph_rle_pixel_decoder_unit_tb OK");
      else
         $display("glyph_rle_pixel_decoder_unit_tb NOT OK");
      $finish;
   end

endmodule
